>>> rtl/gwce_pkg.sv
// Shared types and constants for the working-correlation estimator.
package gwce_pkg;

  localparam int RES_W      = 16;
  localparam int WT_W       = 16;
  localparam int DISP_W     = 16;
  localparam int CSIZE_W    = 5;
  localparam int TOTAL_W    = 64;
  localparam int WSUM_W     = 32;
  localparam int NUM_W      = 60;   // magnitude of the total after dropping four bits
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP  = 2'd2;

  localparam logic MODE_EXCH = 1'b0;
  localparam logic MODE_AR1  = 1'b1;

  localparam logic [CSIZE_W-1:0] CSIZE_RESET = 5'd2;
  localparam logic [DISP_W-1:0]  DISP_RESET  = 16'd256;

  localparam logic [RES_W-1:0] ALPHA_MAX = 16'h7fff;
  localparam logic [RES_W-1:0] ALPHA_MIN = 16'h8000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_WMUL,
    S_WADD,
    S_DMUL1,
    S_DMUL2,
    S_CHK,
    S_DIV,
    S_OUT
  } gwce_state_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic acc;
    logic wmul;
    logic wadd;
    logic dmul1;
    logic dmul2;
    logic div_start;
    logic out_load;
  } gwce_cmd_t;

  typedef struct packed {
    logic commit;
    logic fin;
    logic zero_den;
    logic div_done;
    logic out_free;
  } gwce_sts_t;

endpackage

>>> rtl/gwce_div.sv
// Restoring divider, one quotient bit per cycle.
module gwce_div import gwce_pkg::*; #(
  parameter int DEN_W = 55
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W:0]       trial;
  logic                 ge;
  logic [DEN_W-1:0]     rem_nxt;
  logic [NUM_W-1:0]     quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    ge      = trial >= {1'b0, den};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

>>> rtl/gwce_dp.sv
// Datapath: configuration, cluster accumulators, denominator, divider and result register.
module gwce_dp import gwce_pkg::*; #(
  parameter int MAX_CLUSTER_SIZE = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic signed [RES_W-1:0] in_residual,
  input  logic [WT_W-1:0]       in_cluster_weight,
  input  logic                  in_final_element,
  input  gwce_cmd_t             cmd,
  output gwce_sts_t             sts,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [RES_W-1:0] out_alpha,
  output logic                  out_saturated,
  output logic                  out_zero_denominator
);

  localparam int LOGM  = $clog2(MAX_CLUSTER_SIZE);
  localparam int POSW  = (LOGM < 1) ? 1 : LOGM;
  localparam int MW    = $clog2(MAX_CLUSTER_SIZE + 1);
  localparam int MMW   = 2 * MW;
  localparam int PW    = RES_W + LOGM;          // prefix sum
  localparam int PRW   = RES_W + PW;            // residual product
  localparam int CW    = 2 * RES_W + 2 * LOGM;  // cluster product sum
  localparam int WPW   = CW + WT_W + 1;         // weighted cluster sum
  localparam int KMAX  = MAX_CLUSTER_SIZE * (MAX_CLUSTER_SIZE - 1) / 2;
  localparam int KW    = $clog2(KMAX + 1);
  localparam int TW    = WSUM_W + DISP_W;
  localparam int DW    = TW + KW;

  // configuration
  logic                mode_r;
  logic [CSIZE_W-1:0]  csize_r;
  logic [DISP_W-1:0]   disp_r;

  // per-item and per-cluster state
  logic signed [RES_W-1:0] r_r;
  logic                    fin_r;
  logic [WT_W-1:0]         cur_wt_r;
  logic signed [PW-1:0]    prefix_r;
  logic signed [RES_W-1:0] prev_r;
  logic [POSW-1:0]         pos_r;
  logic signed [PRW-1:0]   prod_r;
  logic signed [CW-1:0]    cps_r;
  logic signed [WPW-1:0]   wprod_r;
  logic [TOTAL_W-1:0]      total_r;
  logic [WSUM_W-1:0]       wsum_r;

  // final estimate
  logic [TW-1:0]           t_r;
  logic [KW-1:0]           k_r;
  logic [DW-1:0]           d_r;
  logic                    neg_r;
  logic [TOTAL_W-1:0]      mag_r;

  logic                    out_valid_r;
  logic [RES_W-1:0]        alpha_r;
  logic                    sat_r;
  logic                    zden_r;

  logic [MW-1:0]           m_eff;
  logic [MW-1:0]           pos_inc;
  logic                    commit;
  logic signed [PW-1:0]    opnd;
  logic [MMW-1:0]          mm;
  logic [NUM_W-1:0]        quo;
  logic                    div_done;
  logic                    zero_den;
  logic                    q_hi;
  logic [RES_W-1:0]        alpha_nxt;
  logic                    sat_nxt;

  always_comb begin
    if (csize_r < CSIZE_W'(2)) begin
      m_eff = MW'(2);
    end else if (32'(csize_r) > MAX_CLUSTER_SIZE) begin
      m_eff = MW'(MAX_CLUSTER_SIZE);
    end else begin
      m_eff = MW'(csize_r);
    end
  end

  assign pos_inc  = MW'(pos_r) + MW'(1);
  assign commit   = pos_inc >= m_eff;
  assign opnd     = (mode_r == MODE_EXCH) ? prefix_r : PW'(prev_r);
  assign mm       = MMW'(m_eff) * MMW'(m_eff - MW'(1));
  assign zero_den = d_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_EXCH;
      csize_r <= CSIZE_RESET;
      disp_r  <= DISP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: mode_r  <= cfg_wdata[0];
        CFG_SIZE: csize_r <= cfg_wdata[CSIZE_W-1:0];
        CFG_DISP: disp_r  <= cfg_wdata[DISP_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_wt_r <= '0;
      prefix_r <= '0;
      prev_r   <= '0;
      pos_r    <= '0;
      cps_r    <= '0;
      total_r  <= '0;
      wsum_r   <= '0;
    end else if (cmd.out_load) begin
      cur_wt_r <= '0;
      prefix_r <= '0;
      prev_r   <= '0;
      pos_r    <= '0;
      cps_r    <= '0;
      total_r  <= '0;
      wsum_r   <= '0;
    end else begin
      if (cmd.accept && pos_r == '0) begin
        // open a new cluster
        cur_wt_r <= in_cluster_weight;
        prefix_r <= '0;
        prev_r   <= '0;
        cps_r    <= '0;
      end
      if (cmd.acc) begin
        if (mode_r == MODE_EXCH || pos_r != '0) begin
          cps_r <= cps_r + CW'(prod_r);
        end
        if (commit) begin
          prefix_r <= '0;
          pos_r    <= '0;
        end else begin
          if (mode_r == MODE_EXCH) begin
            prefix_r <= prefix_r + PW'(r_r);
          end
          pos_r <= POSW'(pos_inc);
        end
        prev_r <= r_r;
      end
      if (cmd.wadd) begin
        total_r <= total_r + TOTAL_W'(wprod_r);
        wsum_r  <= wsum_r + WSUM_W'(cur_wt_r);
        cps_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_r   <= in_residual;
      fin_r <= in_final_element;
    end
    if (cmd.mul) begin
      prod_r <= r_r * opnd;
    end
    if (cmd.wmul) begin
      wprod_r <= cps_r * $signed({1'b0, cur_wt_r});
    end
    if (cmd.dmul1) begin
      t_r   <= wsum_r * disp_r;
      k_r   <= (mode_r == MODE_EXCH) ? KW'(mm >> 1) : KW'(m_eff - MW'(1));
      neg_r <= total_r[TOTAL_W-1];
      mag_r <= total_r[TOTAL_W-1] ? (TOTAL_W'(0) - total_r) : total_r;
    end
    if (cmd.dmul2) begin
      d_r <= t_r * k_r;
    end
  end

  gwce_div #(
    .DEN_W(DW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (mag_r[TOTAL_W-1:TOTAL_W-NUM_W]),
    .den  (d_r),
    .quo  (quo),
    .done (div_done)
  );

  // clip the quotient, sign applied after truncation
  always_comb begin
    q_hi = |quo[NUM_W-1:RES_W];
    if (zero_den) begin
      alpha_nxt = '0;
      sat_nxt   = 1'b0;
    end else if (neg_r) begin
      if (q_hi || quo[RES_W-1:0] > ALPHA_MIN) begin
        alpha_nxt = ALPHA_MIN;
        sat_nxt   = 1'b1;
      end else begin
        alpha_nxt = RES_W'(0) - quo[RES_W-1:0];
        sat_nxt   = 1'b0;
      end
    end else begin
      if (q_hi || quo[RES_W-1]) begin
        alpha_nxt = ALPHA_MAX;
        sat_nxt   = 1'b1;
      end else begin
        alpha_nxt = quo[RES_W-1:0];
        sat_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      alpha_r <= alpha_nxt;
      sat_r   <= sat_nxt;
      zden_r  <= zero_den;
    end
  end

  assign sts.commit   = commit;
  assign sts.fin      = fin_r;
  assign sts.zero_den = zero_den;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_alpha            = $signed(alpha_r);
  assign out_saturated        = sat_r;
  assign out_zero_denominator = zden_r;

endmodule

>>> rtl/gwce_ctrl.sv
// Controller state machine sequencing each item through the datapath.
module gwce_ctrl import gwce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  gwce_sts_t sts,
  output gwce_cmd_t cmd
);

  gwce_state_t state_r;
  gwce_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC: begin
        priority if (sts.commit) state_nxt = S_WMUL;
        else if (sts.fin)        state_nxt = S_DMUL1;
        else                     state_nxt = S_IDLE;
      end
      S_WMUL:  state_nxt = S_WADD;
      S_WADD:  state_nxt = sts.fin ? S_DMUL1 : S_IDLE;
      S_DMUL1: state_nxt = S_DMUL2;
      S_DMUL2: state_nxt = S_CHK;
      S_CHK:   state_nxt = sts.zero_den ? S_OUT : S_DIV;
      S_DIV:   if (sts.div_done) state_nxt = S_OUT;
      S_OUT:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.accept    = in_valid;
      S_MUL:   cmd.mul       = 1'b1;
      S_ACC:   cmd.acc       = 1'b1;
      S_WMUL:  cmd.wmul      = 1'b1;
      S_WADD:  cmd.wadd      = 1'b1;
      S_DMUL1: cmd.dmul1     = 1'b1;
      S_DMUL2: cmd.dmul2     = 1'b1;
      S_CHK:   cmd.div_start = !sts.zero_den;
      S_DIV:   ;
      S_OUT:   cmd.out_load  = sts.out_free;
      default: ;
    endcase
  end

  assign in_stall = state_r != S_IDLE;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register occupied");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !sts.div_done) |=> state_r == S_DIV)
    else $error("left divide wait before quotient ready");

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("divider finished immediately after start");

  a_accept_ack: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (in_stall && state_r == S_MUL))
    else $error("accepted item not sequenced");

endmodule

>>> rtl/gee_working_correlation_estimator.sv
// Top level of the GEE working-correlation moment estimator.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall  in_residual, in_cluster_weight, in_final_element
//   out_     out  out_valid/out_stall  out_alpha, out_saturated, out_zero_denominator
//   cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// An item passes through the accept, multiply and accumulate steps; an item that completes
// a cluster adds the weight multiply and add. A final item then adds denominator setup, the
// bit-serial restoring divider (one quotient bit per cycle, skipped on a zero denominator)
// and a load of the result register.
// Reset is synchronous, active low; it restores the configuration defaults and
// clears all accumulators.
// The result register holds an estimate under out_stall while later items are
// taken; a final item waits in its last step until that register is free.
module gee_working_correlation_estimator import gwce_pkg::*; #(
  parameter int MAX_CLUSTER_SIZE = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RES_W-1:0] in_residual,
  input  logic [WT_W-1:0]         in_cluster_weight,
  input  logic                    in_final_element,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] out_alpha,
  output logic                    out_saturated,
  output logic                    out_zero_denominator
);

  gwce_cmd_t cmd;
  gwce_sts_t sts;

  gwce_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  gwce_dp #(
    .MAX_CLUSTER_SIZE(MAX_CLUSTER_SIZE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_residual         (in_residual),
    .in_cluster_weight   (in_cluster_weight),
    .in_final_element    (in_final_element),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_alpha           (out_alpha),
    .out_saturated       (out_saturated),
    .out_zero_denominator(out_zero_denominator)
  );

endmodule

>>> sim/gee_working_correlation_estimator_tb.sv
// Testbench for the working-correlation estimator: directed and random data sets, checked estimate by estimate.
`timescale 1ns / 1ps

module gee_working_correlation_estimator_tb;
  import gwce_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int ITEM_SETTLE  = 12;    // longest item is one that completes a cluster
  localparam int END_SETTLE   = 100;   // final item: setup, divider and load
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_SIZE     = 16;

  typedef struct {
    logic signed [RES_W-1:0] alpha;
    logic                    sat;
    logic                    zden;
  } estimate_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [RES_W-1:0] in_residual;
  logic [WT_W-1:0]         in_cluster_weight;
  logic                    in_final_element;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [RES_W-1:0] out_alpha;
  logic                    out_saturated;
  logic                    out_zero_denominator;

  gee_working_correlation_estimator #(
    .MAX_CLUSTER_SIZE(MAX_SIZE)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_residual          (in_residual),
    .in_cluster_weight    (in_cluster_weight),
    .in_final_element     (in_final_element),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_alpha            (out_alpha),
    .out_saturated        (out_saturated),
    .out_zero_denominator (out_zero_denominator)
  );

  // Estimator shadow: configuration and accumulators
  logic                reg_mode;
  logic [CSIZE_W-1:0]  reg_size;
  logic [DISP_W-1:0]   reg_disp;
  logic [TOTAL_W-1:0]  acc_total;
  logic [WSUM_W-1:0]   acc_wsum;
  longint              clus_sum;
  int                  prefix_sum;
  logic signed [15:0]  last_res;
  int                  clus_pos;
  logic [WT_W-1:0]     clus_weight;

  estimate_t pending_estimates[$];

  int  error_count;
  int  cycle_count;
  int  random_items;
  int  hold_left = 0;
  bit  no_idle;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("tb: mismatch on %s: expected %0d, got %0d", what, want, got);
    error_count++;
  endtask

  function automatic int effective_cluster_size();
    if (reg_size < 2) return 2;
    if (reg_size > MAX_SIZE) return MAX_SIZE;
    return int'(reg_size);
  endfunction

  function automatic void clear_estimator();
    acc_total   = '0;
    acc_wsum    = '0;
    clus_sum    = 0;
    prefix_sum  = 0;
    last_res    = '0;
    clus_pos    = 0;
    clus_weight = '0;
  endfunction

  // Fold one residual into the shadow state; queue an estimate on a final item.
  function automatic void absorb_residual(input logic signed [15:0] r, input logic [15:0] w,
                                          input logic fin);
    int             m;
    int             k;
    logic [63:0]    sum_bits;
    logic [63:0]    den;
    logic [63:0]    mag;
    logic [63:0]    quo;
    logic [15:0]    q16;
    logic           neg;
    estimate_t      e;
    m = effective_cluster_size();
    if (clus_pos == 0) begin
      clus_weight = w;
      clus_sum    = 0;
      prefix_sum  = 0;
      last_res    = '0;
    end
    if (reg_mode == MODE_EXCH) begin
      clus_sum   += longint'(r) * longint'(prefix_sum);
      prefix_sum += int'(r);
    end else if (clus_pos > 0) begin
      clus_sum += longint'(last_res) * longint'(r);
    end
    last_res = r;
    clus_pos++;
    if (clus_pos >= m) begin
      sum_bits   = clus_sum;
      acc_total  = acc_total + sum_bits * {48'd0, clus_weight};
      acc_wsum   = acc_wsum + {16'd0, clus_weight};
      clus_pos   = 0;
      clus_sum   = 0;
      prefix_sum = 0;
    end
    if (!fin) return;
    k   = (reg_mode == MODE_EXCH) ? m * (m - 1) / 2 : m - 1;
    den = 64'(k) * {32'd0, acc_wsum} * {48'd0, reg_disp};
    e.alpha = '0;
    e.sat   = 1'b0;
    e.zden  = 1'b0;
    if (den == 0) begin
      e.zden = 1'b1;
    end else begin
      neg = acc_total[63];
      mag = neg ? 64'd0 - acc_total : acc_total;
      quo = (mag >> 4) / den;
      if (neg && quo > 64'd32768) begin
        quo   = 64'd32768;
        e.sat = 1'b1;
      end else if (!neg && quo > 64'd32767) begin
        quo   = 64'd32767;
        e.sat = 1'b1;
      end
      q16     = quo[15:0];
      e.alpha = neg ? 16'd0 - q16 : q16;
    end
    pending_estimates.push_back(e);
    clear_estimator();
  endfunction

  // Send one residual; returns at the edge that accepts it, valid still high.
  task automatic send_residual(input logic signed [15:0] r, input logic [15:0] w,
                               input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_residual       <= r;
    in_cluster_weight <= w;
    in_final_element  <= fin;
    do @(posedge clk); while (in_stall);
    absorb_residual(r, w, fin);
  endtask

  // Drop valid, let every estimate come back, then let the block settle.
  task automatic wait_quiet(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_MODE: reg_mode = data[0];
      CFG_SIZE: reg_size = data[CSIZE_W-1:0];
      CFG_DISP: reg_disp = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result checker and receiver hold-off; count down only while an estimate is offered.
  always @(posedge clk) begin : check_estimate
    estimate_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("unexpected estimate alpha", 0, out_alpha);
      end else begin
        want = pending_estimates.pop_front();
        if (out_alpha !== want.alpha)
          report_mismatch("alpha", want.alpha, out_alpha);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", want.sat, out_saturated);
        if (out_zero_denominator !== want.zden)
          report_mismatch("zero_denominator", want.zden, out_zero_denominator);
      end
      hold_left = no_idle ? 0 : $urandom_range(0, 16);
    end else if (rst_n && out_valid && hold_left > 0) begin
      hold_left--;
    end
  end

  // Hold stall while cycles remain.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_left > 0;
    end
  end

  function automatic logic signed [15:0] pick_residual();
    int sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return 16'shffff;
          default: return 16'sh0001;
        endcase
      end
      1, 2: return 16'($urandom);
      default: return 16'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 1023));
    endcase
  endfunction

  // Mostly whole clusters ending in a final item; some trailing partials and noise.
  task automatic send_data_set();
    int m;
    int n;
    int kind;
    m    = effective_cluster_size();
    kind = $urandom_range(0, 9);
    if (kind < 7)
      n = m * $urandom_range(1, 4);
    else if (kind < 9)
      n = m * $urandom_range(0, 3) + $urandom_range(1, m - 1);
    else
      n = $urandom_range(1, 2 * m);
    for (int i = 0; i < n; i++)
      send_residual(pick_residual(), pick_weight(), i == n - 1);
    random_items += n;
  endtask

  task automatic test_default_extremes();
    send_residual(16'sh7fff, 16'hffff, 1'b0);
    send_residual(16'sh7fff, 16'h0000, 1'b1);
    send_residual(16'sh8000, 16'hffff, 1'b0);
    send_residual(16'sh7fff, 16'h0001, 1'b1);
    send_residual(16'sd4096, 16'd256, 1'b0);
    send_residual(16'sd2048, 16'd256, 1'b1);
  endtask

  task automatic test_zero_denominator();
    send_residual(16'sd1000, 16'd300, 1'b1);
    send_residual(16'sd500, 16'd0, 1'b0);
    send_residual(-16'sd700, 16'd77, 1'b1);
    wait_quiet(ITEM_SETTLE);
    write_register(CFG_DISP, 16'd0);
    send_residual(16'sd4096, 16'd256, 1'b0);
    send_residual(16'sd4096, 16'd256, 1'b1);
  endtask

  task automatic test_register_extremes();
    wait_quiet(ITEM_SETTLE);
    write_register(CFG_MODE, 16'(MODE_AR1));
    write_register(CFG_SIZE, 16'd1);
    write_register(CFG_DISP, 16'd1);
    send_residual(16'sd4096, 16'd256, 1'b0);
    send_residual(-16'sd4096, 16'd1, 1'b1);
    wait_quiet(ITEM_SETTLE);
    write_register(CFG_SIZE, 16'd0);
    write_register(CFG_DISP, 16'hffff);
    send_residual(16'sd8191, 16'hffff, 1'b0);
    send_residual(16'sd8191, 16'd0, 1'b1);
  endtask

  task automatic test_size_change_mid_cluster();
    wait_quiet(ITEM_SETTLE);
    write_register(CFG_MODE, 16'(MODE_EXCH));
    write_register(CFG_SIZE, 16'd4);
    write_register(CFG_DISP, 16'd256);
    send_residual(16'sd3000, 16'd200, 1'b0);
    send_residual(-16'sd1500, 16'd9, 1'b0);
    send_residual(16'sd2500, 16'd9, 1'b0);
    // shrink below the current count: the next item closes the cluster
    wait_quiet(ITEM_SETTLE);
    write_register(CFG_SIZE, 16'd2);
    send_residual(16'sd1200, 16'd9, 1'b1);
  endtask

  task automatic test_mode_change_mid_stream();
    wait_quiet(ITEM_SETTLE);
    write_register(CFG_SIZE, 16'd3);
    send_residual(16'sd2000, 16'd512, 1'b0);
    send_residual(16'sd3000, 16'd5, 1'b0);
    wait_quiet(ITEM_SETTLE);
    write_register(CFG_MODE, 16'(MODE_AR1));
    send_residual(-16'sd4000, 16'd5, 1'b1);
  endtask

  task automatic test_partial_cluster_dropped();
    wait_quiet(ITEM_SETTLE);
    write_register(CFG_MODE, 16'(MODE_EXCH));
    write_register(CFG_SIZE, 16'd2);
    send_residual(16'sd4096, 16'd256, 1'b0);
    send_residual(16'sd1024, 16'd3, 1'b0);
    send_residual(16'sh7fff, 16'hffff, 1'b1);
  endtask

  task automatic test_random_data_sets();
    logic [CSIZE_W-1:0] size_pick;
    logic [DISP_W-1:0]  disp_pick;
    while (random_items < RANDOM_ITEMS) begin
      wait_quiet(ITEM_SETTLE);
      case ($urandom_range(0, 19))
        0, 1, 2:    size_pick = 5'($urandom_range(0, 31));
        3, 4, 5:    size_pick = 5'($urandom_range(6, 16));
        default:    size_pick = 5'($urandom_range(2, 5));
      endcase
      case ($urandom_range(0, 19))
        0:       disp_pick = 16'd0;
        1:       disp_pick = 16'd1;
        2:       disp_pick = 16'hffff;
        3:       disp_pick = 16'($urandom);
        default: disp_pick = 16'($urandom_range(64, 1023));
      endcase
      write_register(CFG_MODE, 16'($urandom_range(0, 1)));
      write_register(CFG_SIZE, 16'(size_pick));
      write_register(CFG_DISP, disp_pick);
      no_idle = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 4)) send_data_set();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_residual       = '0;
    in_cluster_weight = '0;
    in_final_element  = 1'b0;
    error_count       = 0;
    cycle_count       = 0;
    random_items      = 0;
    no_idle           = 1'b0;
    reg_mode          = MODE_EXCH;
    reg_size          = CSIZE_RESET;
    reg_disp          = DISP_RESET;
    clear_estimator();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_extremes();
    test_zero_denominator();
    test_register_extremes();
    test_size_change_mid_cluster();
    test_mode_change_mid_stream();
    test_partial_cluster_dropped();
    test_random_data_sets();

    wait_quiet(END_SETTLE);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
